// ===== design/assert_macros.svh =====
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LMT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lmt_pkg.sv =====
// Types and constants for the LCD mode timing block.
`default_nettype none

package lmt_pkg;

  localparam int unsigned POS_W  = 7;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned CYC_W  = 6;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_e;

  // register indexes (word address)
  localparam logic [1:0] REG_LCD_ENABLED      = 2'd0;
  localparam logic [1:0] REG_COMPARE_LINE     = 2'd1;
  localparam logic [1:0] REG_STAT_INT_ENABLES = 2'd2;

  // stat interrupt enable bit positions
  localparam int unsigned IE_HBLANK = 0;
  localparam int unsigned IE_VBLANK = 1;
  localparam int unsigned IE_OAM    = 2;
  localparam int unsigned IE_COINC  = 3;

  typedef struct packed {
    logic        enabled;
    logic [7:0]  compare_line;
    logic [3:0]  int_enables;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [LINE_W-1:0] line;
    lcd_mode_e         mode;
    logic              coin;
  } state_t;

  typedef struct packed {
    lcd_mode_e         mode;
    logic [LINE_W-1:0] line;
    logic              coin;
    logic              stat_irq;
    logic              vblank_irq;
    logic              frame_done;
    logic              sprite_start;
    logic              render_start;
  } result_t;

endpackage

`default_nettype wire

// ===== design/lmt_cfg_regs.sv =====
// APB-style configuration registers of the LCD mode timing block.
`default_nettype none

module lmt_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lmt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lmt_pkg::DATA_W-1:0] pwdata,
  output logic      [lmt_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output lmt_pkg::cfg_t                   cfg_o
);

  lmt_pkg::cfg_t cfg_q;
  logic [1:0]    idx;
  logic          wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled      <= 1'b1;
      cfg_q.compare_line <= '0;
      cfg_q.int_enables  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        lmt_pkg::REG_LCD_ENABLED:      cfg_q.enabled      <= pwdata[0];
        lmt_pkg::REG_COMPARE_LINE:     cfg_q.compare_line <= pwdata[7:0];
        lmt_pkg::REG_STAT_INT_ENABLES: cfg_q.int_enables  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lmt_pkg::REG_LCD_ENABLED:      prdata = {31'b0, cfg_q.enabled};
      lmt_pkg::REG_COMPARE_LINE:     prdata = {24'b0, cfg_q.compare_line};
      lmt_pkg::REG_STAT_INT_ENABLES: prdata = {28'b0, cfg_q.int_enables};
      default:                       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/lmt_step.sv =====
// Next-state and result logic for one cycles word.
`default_nettype none

module lmt_step #(
  parameter int unsigned LINE_CLOCKS      = 114,
  parameter int unsigned FIRST_BLANK_LINE = 144,
  parameter int unsigned LINES_PER_FRAME  = 154,
  parameter int unsigned OAM_CLOCKS       = 20,
  parameter int unsigned TRANSFER_CLOCKS  = 43
) (
  input  wire logic [lmt_pkg::CYC_W-1:0] cycles_i,
  input  lmt_pkg::state_t                st_i,
  input  lmt_pkg::cfg_t                  cfg_i,
  output lmt_pkg::state_t                st_o,
  output lmt_pkg::result_t               res_o
);

  logic [7:0]                 pos_sum;
  logic                       wrap;
  logic [lmt_pkg::POS_W-1:0]  pos_next;
  logic [8:0]                 line_inc;
  logic [lmt_pkg::LINE_W-1:0] line_next;
  lmt_pkg::lcd_mode_e         mode;
  logic                       line_chg;
  logic                       coin_next;
  logic                       stat, vbl, frame, sprite, render;

  assign pos_sum  = {1'b0, st_i.pos} + {2'b00, cycles_i};
  assign wrap     = pos_sum >= 8'(LINE_CLOCKS);
  assign pos_next = wrap ? 7'(pos_sum - 8'(LINE_CLOCKS)) : pos_sum[6:0];
  assign line_inc = {1'b0, st_i.line} + 9'd1;

  always_comb begin
    if (!wrap)                                line_next = st_i.line;
    else if (line_inc >= 9'(LINES_PER_FRAME)) line_next = '0;
    else                                      line_next = line_inc[7:0];
  end

  always_comb begin
    if (!cfg_i.enabled)                         mode = lmt_pkg::MODE_HBLANK;
    else if (line_next >= 8'(FIRST_BLANK_LINE)) mode = lmt_pkg::MODE_VBLANK;
    else if (pos_next < 7'(OAM_CLOCKS))         mode = lmt_pkg::MODE_OAM;
    else if (pos_next < 7'(OAM_CLOCKS + TRANSFER_CLOCKS))
                                                mode = lmt_pkg::MODE_XFER;
    else                                        mode = lmt_pkg::MODE_HBLANK;
  end

  assign line_chg  = line_next != st_i.line;
  assign coin_next = line_chg ? (line_next == cfg_i.compare_line) : st_i.coin;

  // pulses keyed on the mode being left, plus the coincidence stat on a line change
  always_comb begin
    stat   = line_chg & coin_next & cfg_i.int_enables[lmt_pkg::IE_COINC];
    vbl    = 1'b0;
    frame  = 1'b0;
    sprite = 1'b0;
    render = 1'b0;
    if (mode != st_i.mode) begin
      case (st_i.mode)
        lmt_pkg::MODE_HBLANK: begin
          if (mode == lmt_pkg::MODE_VBLANK) begin
            frame = 1'b1;
            vbl   = 1'b1;
            stat  = stat | cfg_i.int_enables[lmt_pkg::IE_VBLANK];
          end else if (mode == lmt_pkg::MODE_OAM) begin
            sprite = 1'b1;
            stat   = stat | cfg_i.int_enables[lmt_pkg::IE_OAM];
          end
        end
        lmt_pkg::MODE_VBLANK: begin
          sprite = 1'b1;
          stat   = stat | cfg_i.int_enables[lmt_pkg::IE_OAM];
        end
        lmt_pkg::MODE_OAM: begin
          render = 1'b1;
        end
        lmt_pkg::MODE_XFER: begin
          stat = stat | (cfg_i.enabled & cfg_i.int_enables[lmt_pkg::IE_HBLANK]);
        end
      endcase
    end
  end

  assign st_o.pos  = pos_next;
  assign st_o.line = line_next;
  assign st_o.mode = mode;
  assign st_o.coin = coin_next;

  assign res_o.mode         = mode;
  assign res_o.line         = line_next;
  assign res_o.coin         = coin_next;
  assign res_o.stat_irq     = stat;
  assign res_o.vblank_irq   = vbl;
  assign res_o.frame_done   = frame;
  assign res_o.sprite_start = sprite;
  assign res_o.render_start = render;

endmodule

`default_nettype wire

// ===== design/lcd_mode_timing_core.sv =====
// Top level of the LCD mode timing block: word pipeline, state and registers.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o, cycles_i): one word per batch of
//    machine cycles elapsed since the previous word, below one line length.
//  - Output channel (out_valid_o / out_ready_i): exactly one result word per
//    input word, in order: LCD mode, line number, coincidence flag and the
//    interrupt / task request pulses caused by that step.
//  - Config port: APB-style, registers at byte 0 (enable), 4 (compare line),
//    8 (stat interrupt enables); pready is tied high. Write only while idle.
//  - A word accepted lands in the input register; its result is loaded into the
//    output register once that register is free or being drained, and is then
//    offered on the output channel.
//  - Throughput: one word per clock while out_ready_i is high. The timing state
//    (position, line, last reported mode, coincidence) is updated by a single
//    add/compare pass between the input register and the output register.
//  - Stall: while a result waits, the input register still takes one word;
//    both stages then hold and in_ready_o drops until out_ready_i returns.
//  - Reset: position and line clear, reported mode is vblank, coincidence set,
//    display enabled, compare line and interrupt enables zero, no word held.
`default_nettype none

module lcd_mode_timing_core #(
  parameter int unsigned LINE_CLOCKS      = 114,
  parameter int unsigned FIRST_BLANK_LINE = 144,
  parameter int unsigned LINES_PER_FRAME  = 154,
  parameter int unsigned OAM_CLOCKS       = 20,
  parameter int unsigned TRANSFER_CLOCKS  = 43
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // input channel
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [lmt_pkg::CYC_W-1:0]  cycles_i,
  // output channel
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [1:0]                      lcd_mode_o,
  output logic [lmt_pkg::LINE_W-1:0]      line_index_o,
  output logic                            coincidence_o,
  output logic                            stat_irq_o,
  output logic                            vblank_irq_o,
  output logic                            frame_done_o,
  output logic                            sprite_search_start_o,
  output logic                            line_render_start_o,
  // config port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lmt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lmt_pkg::DATA_W-1:0] pwdata,
  output logic      [lmt_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  lmt_pkg::cfg_t    cfg;
  lmt_pkg::state_t  st_q, st_d;
  lmt_pkg::result_t res_d, res_q;

  logic                      in_vld_q;
  logic [lmt_pkg::CYC_W-1:0] cycles_q;
  logic                      out_vld_q;
  logic                      advance;

  lmt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lmt_step #(
    .LINE_CLOCKS      (LINE_CLOCKS),
    .FIRST_BLANK_LINE (FIRST_BLANK_LINE),
    .LINES_PER_FRAME  (LINES_PER_FRAME),
    .OAM_CLOCKS       (OAM_CLOCKS),
    .TRANSFER_CLOCKS  (TRANSFER_CLOCKS)
  ) u_step (
    .cycles_i (cycles_q),
    .st_i     (st_q),
    .cfg_i    (cfg),
    .st_o     (st_d),
    .res_o    (res_d)
  );

  // input word moves on when the output register is free or being drained
  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cycles_q <= cycles_i;
    end
  end

  // timing state commits once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.pos  <= '0;
      st_q.line <= '0;
      st_q.mode <= lmt_pkg::MODE_VBLANK;
      st_q.coin <= 1'b1;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o           = out_vld_q;
  assign lcd_mode_o            = res_q.mode;
  assign line_index_o          = res_q.line;
  assign coincidence_o         = res_q.coin;
  assign stat_irq_o            = res_q.stat_irq;
  assign vblank_irq_o          = res_q.vblank_irq;
  assign frame_done_o          = res_q.frame_done;
  assign sprite_search_start_o = res_q.sprite_start;
  assign line_render_start_o   = res_q.render_start;

endmodule

`default_nettype wire

// ===== design/lmt_port_checker.sv =====
// Port-level checker for the LCD mode timing block, with its bind.
`default_nettype none
`include "assert_macros.svh"

module lmt_port_checker #(
  parameter int unsigned FIRST_BLANK_LINE = 144,
  parameter int unsigned LINES_PER_FRAME  = 154
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [1:0]                 lcd_mode_o,
  input wire logic [lmt_pkg::LINE_W-1:0] line_index_o,
  input wire logic                       vblank_irq_o,
  input wire logic                       frame_done_o
);

  `LMT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(lcd_mode_o) && $stable(line_index_o), "result word changed while stalled")

  `LMT_ASSERT_IMPL(a_line_range, clk_i, rst_ni, out_valid_o, 9'(line_index_o) < 9'(LINES_PER_FRAME), "line index beyond frame")

  `LMT_ASSERT_IMPL(a_vblank_line, clk_i, rst_ni, out_valid_o && lcd_mode_o == lmt_pkg::MODE_VBLANK, 9'(line_index_o) >= 9'(FIRST_BLANK_LINE), "vblank mode before first blank line")

  `LMT_ASSERT_IMPL(a_frame_vbl, clk_i, rst_ni, out_valid_o && frame_done_o, vblank_irq_o && lcd_mode_o == lmt_pkg::MODE_VBLANK, "frame done without vblank entry")

endmodule

bind lcd_mode_timing_core lmt_port_checker #(
  .FIRST_BLANK_LINE (FIRST_BLANK_LINE),
  .LINES_PER_FRAME  (LINES_PER_FRAME)
) u_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .lcd_mode_o   (lcd_mode_o),
  .line_index_o (line_index_o),
  .vblank_irq_o (vblank_irq_o),
  .frame_done_o (frame_done_o)
);

`default_nettype wire
